// ----- rtl/core/itp_pkg.sv -----
// Shared types, character codes and precedence helpers for the infix to postfix converter.
// Used by the datapath, the controller and the top level. No dependencies.
package itp_pkg;

	localparam int SYM_W           = 8;
	localparam int RANK_W          = 2;
	localparam int STK_W           = SYM_W + RANK_W;
	localparam int STACK_DEPTH_DEF = 16;

	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [RANK_W-1:0] rank_t;

	localparam sym_t CH_PLUS  = 8'h2B;
	localparam sym_t CH_MINUS = 8'h2D;
	localparam sym_t CH_STAR  = 8'h2A;
	localparam sym_t CH_SLASH = 8'h2F;

	localparam rank_t RANK_NONE = 2'd0;
	localparam rank_t RANK_ADD  = 2'd2;
	localparam rank_t RANK_MUL  = 2'd3;

	typedef struct packed {
		logic capture;
		logic emit;
		logic src_stack;
		logic run_last;
		logic expr_done;
		logic pop;
		logic push;
		logic drop;
		logic clr_ovf;
	} itp_cmd_t;

	typedef struct packed {
		logic in_is_op;
		logic last;
		logic cnt_zero;
		logic cnt_one;
		logic full;
		logic pop_cond;
		logic below_ge;
		logic slot_free;
	} itp_sts_t;

	function automatic rank_t rank_of(input sym_t c);
		rank_t r;
		case (c) inside
			CH_STAR, CH_SLASH: r = RANK_MUL;
			CH_PLUS, CH_MINUS: r = RANK_ADD;
			default:           r = RANK_NONE;
		endcase
		return r;
	endfunction

	function automatic logic is_op(input sym_t c);
		return rank_of(c) != RANK_NONE;
	endfunction

endpackage

// ----- rtl/core/itp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/itp_datapath.sv -----
// Datapath: input capture, operator stack in RAM with count, sticky overflow flag, output register.
// Depends on itp_pkg and itp_ram.
module itp_datapath #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  itp_pkg::sym_t     symbol,
	input  logic              expr_end,
	input  itp_pkg::itp_cmd_t cmd,
	output itp_pkg::itp_sts_t sts,
	input  logic              out_ready,
	output logic              out_valid,
	output itp_pkg::sym_t     out_symbol,
	output logic              run_last,
	output logic              expr_done,
	output logic              overflow
);
	import itp_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	sym_t             sym_q;
	logic             last_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic [CW-1:0]    count_m1;
	logic             ovf_q;
	logic             out_valid_q;
	sym_t             out_symbol_q;
	logic             run_last_q;
	logic             expr_done_q;
	logic             overflow_q;
	logic [STK_W-1:0] rd_data;
	logic [STK_W-1:0] wr_data;
	sym_t             top_sym;
	rank_t            top_rank;
	rank_t            below_rank;
	rank_t            new_rank;
	rank_t            push_below;

	assign top_sym    = rd_data[SYM_W-1:0];
	assign below_rank = rd_data[STK_W-1:SYM_W];
	assign top_rank   = rank_of(top_sym);
	assign new_rank   = rank_of(sym_q);
	assign push_below = (count_q != '0) ? top_rank : RANK_NONE;
	assign wr_data    = {push_below, sym_q};

	always_comb begin
		count_d = count_q;
		if (cmd.pop) begin
			count_d = count_q - CW'(1);
		end else if (cmd.push) begin
			count_d = count_q + CW'(1);
		end
	end

	assign count_m1 = count_d - CW'(1);

	itp_ram #(
		.WIDTH(STK_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(count_q[AW-1:0]),
		.wdata(wr_data),
		.raddr(count_m1[AW-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		sts.in_is_op  = is_op(symbol);
		sts.last      = last_q;
		sts.cnt_zero  = (count_q == '0);
		sts.cnt_one   = (count_q == CW'(1));
		sts.full      = (count_q == CW'(STACK_DEPTH));
		sts.pop_cond  = (count_q != '0) && (top_rank >= new_rank);
		sts.below_ge  = (below_rank >= new_rank);
		sts.slot_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				last_q <= expr_end;
			end
			count_q <= count_d;
			if (cmd.drop) begin
				ovf_q <= 1'b1;
			end else if (cmd.clr_ovf) begin
				ovf_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sym_q <= symbol;
		end
		if (cmd.emit) begin
			out_symbol_q <= cmd.src_stack ? top_sym : sym_q;
			run_last_q   <= cmd.run_last;
			expr_done_q  <= cmd.expr_done;
			overflow_q   <= cmd.expr_done & ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_symbol_q;
	assign run_last   = run_last_q;
	assign expr_done  = expr_done_q;
	assign overflow   = overflow_q;

endmodule

// ----- rtl/core/itp_ctrl.sv -----
// Controller: sequences operand emission, operator pops and push, and the end-of-expression flush.
// Depends on itp_pkg.
module itp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  itp_pkg::itp_sts_t sts,
	output itp_pkg::itp_cmd_t cmd
);
	import itp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_OPND   = 5'b00010,
		S_POP    = 5'b00100,
		S_SETTLE = 5'b01000,
		S_FLUSH  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = sts.in_is_op ? S_POP : S_OPND;
				end
			end
			S_OPND: begin
				if (sts.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.run_last  = !sts.last || sts.cnt_zero;
					cmd.expr_done = sts.last && sts.cnt_zero;
					cmd.clr_ovf   = sts.last && sts.cnt_zero;
					state_d       = (sts.last && !sts.cnt_zero) ? S_FLUSH : S_IDLE;
				end
			end
			S_POP: begin
				if (sts.pop_cond) begin
					if (sts.slot_free) begin
						cmd.emit      = 1'b1;
						cmd.src_stack = 1'b1;
						cmd.pop       = 1'b1;
						cmd.run_last  = !sts.last && !sts.below_ge;
					end
				end else begin
					cmd.push = !sts.full;
					cmd.drop = sts.full;
					if (!sts.last) begin
						state_d = S_IDLE;
					end else begin
						state_d = sts.full ? S_FLUSH : S_SETTLE;
					end
				end
			end
			S_SETTLE: begin
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (sts.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.src_stack = 1'b1;
					cmd.pop       = 1'b1;
					cmd.run_last  = sts.cnt_one;
					cmd.expr_done = sts.cnt_one;
					cmd.clr_ovf   = sts.cnt_one;
					if (sts.cnt_one) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/infix_to_postfix_converter_core.sv -----
// Infix to postfix converter (shunting-yard, no parentheses). Depends on itp_pkg, itp_ctrl,
// itp_datapath and itp_ram. One item at a time: an operand is captured, then emitted; an operator
// is captured, pops one entry per cycle through the stack RAM read port while the output slot is
// free, then is pushed; a final character adds a settle state after a push, then flushes the stack.
// Reset (arst_n low) empties the stack, clears the overflow flag and the output valid flag.
module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  itp_pkg::sym_t symbol,
	input  logic          expr_end,
	output logic          out_valid,
	input  logic          out_ready,
	output itp_pkg::sym_t out_symbol,
	output logic          run_last,
	output logic          expr_done,
	output logic          overflow
);
	import itp_pkg::*;

	itp_cmd_t cmd;
	itp_sts_t sts;

	itp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	itp_datapath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.symbol    (symbol),
		.expr_end  (expr_end),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_symbol(out_symbol),
		.run_last  (run_last),
		.expr_done (expr_done),
		.overflow  (overflow)
	);

endmodule

// ----- rtl/core/itp_checker.sv -----
// Port-level checker for the infix to postfix converter, bound to the top level.
// Depends on itp_pkg and infix_to_postfix_converter_core.
module itp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input itp_pkg::sym_t out_symbol,
	input logic          run_last,
	input logic          expr_done,
	input logic          overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(run_last)
			&& $stable(expr_done) && $stable(overflow))
		else $error("output transaction changed while stalled");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expr_done |-> run_last)
		else $error("final result of expression not marked last of its item");

	a_ovf_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> expr_done)
		else $error("overflow reported on a non-final result");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous transaction still in progress");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);
